// ----- hdl/pwu_pkg.sv -----
// Shared types, register indexes and constants of the periodic waveform unit.
`timescale 1ns / 1ps

package pwu_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int N_STAGES  = 7;

  typedef enum logic [1:0] {
    WAVE_SAW   = 2'd0,
    WAVE_TRI   = 2'd1,
    WAVE_SINE  = 2'd2,
    WAVE_GAUSS = 2'd3
  } wave_e;

  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SPAN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE     = 2'd3;

  localparam logic [DATA_W-1:0] INV_SPAN_RESET  = 32'h0001_0000;
  localparam logic [DATA_W-1:0] AMPLITUDE_RESET = 32'h0001_0000;
  localparam logic [DATA_W-1:0] SAT_POS         = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG         = 32'h8000_0000;

  // pi/2 with 60 fractional bits.
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921_FB54_442D_1846;

  // Truncated (a * b) >> 60 of two Q60 values.
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

endpackage

// ----- hdl/pwu_phase.sv -----
// Phase stages: offset subtract, split multiply by the reciprocal span, fraction of a turn.
`timescale 1ns / 1ps

module pwu_phase #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  pwu_pkg::wave_e       wave_sel_i,
  input  logic [31:0]          phase_i,
  input  logic [31:0]          inv_span_i,
  input  logic [31:0]          sample_x_i,
  output logic [FRAC_BITS-1:0] u_o
);

  localparam int PW = 2 * FRAC_BITS;

  logic        [32:0]          d_d, d_q;
  logic        [47:0]          pp_lo_d, pp_lo_q;
  logic signed [49:0]          pp_hi_d, pp_hi_q;
  logic        [63:0]          ph_wide;
  logic        [63:0]          off_wide;
  logic        [65:0]          hi_sh;
  logic        [PW-1:0]        off;
  logic        [PW-1:0]        turns;
  logic        [FRAC_BITS-1:0] u_q;

  // Sine mode takes x alone; its phase term is subtracted after the product.
  always_comb begin
    if (wave_sel_i == pwu_pkg::WAVE_SINE) begin
      d_d = {sample_x_i[31], sample_x_i};
    end else begin
      d_d = {sample_x_i[31], sample_x_i} - {phase_i[31], phase_i};
    end
  end

  always_comb begin
    pp_lo_d = {32'd0, d_q[15:0]} * {16'd0, inv_span_i};
    pp_hi_d = $signed(d_q[32:16]) * $signed({1'b0, inv_span_i});
  end

  // Only the low 2F bits of the turn count matter, so the sum wraps there.
  always_comb begin
    ph_wide  = {{32{phase_i[31]}}, phase_i};
    off_wide = ph_wide << (FRAC_BITS - 1);
    off      = (wave_sel_i == pwu_pkg::WAVE_SINE) ? off_wide[PW-1:0] : '0;
    hi_sh    = {pp_hi_q, 16'd0};
    turns    = pp_lo_q[PW-1:0] + hi_sh[PW-1:0] - off;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d_q <= d_d;
    end
    if (en_i[1]) begin
      pp_lo_q <= pp_lo_d;
      pp_hi_q <= pp_hi_d;
    end
    if (en_i[2]) begin
      u_q <= turns[PW-1:FRAC_BITS];
    end
  end

  assign u_o = u_q;

endmodule

// ----- hdl/pwu_wave_rom.sv -----
// Wave shaping stages: quarter-wave sine table lookup and multiplier operand.
`timescale 1ns / 1ps

module pwu_wave_rom #(
  parameter int SINE_TABLE_ADDR_BITS = 10,
  parameter int FRAC_BITS            = 16
) (
  input  logic                        clk_i,
  input  logic [1:0]                  en_i,
  input  pwu_pkg::wave_e              wave_sel_i,
  input  logic [FRAC_BITS-1:0]        u_i,
  output logic signed [FRAC_BITS+2:0] op_o
);

  localparam int AB    = SINE_TABLE_ADDR_BITS;
  localparam int PB    = FRAC_BITS - 2;
  localparam int TAB_N = 1 << AB;
  localparam int OW    = FRAC_BITS + 3;

  typedef logic [FRAC_BITS:0] rom_t [TAB_N+1];

  // Taylor series of sin in Q60, rounded to F fractional bits.
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] rnd;
    logic signed [63:0] sum;
    for (int i = 0; i <= TAB_N; i++) begin
      th   = pwu_pkg::mul_q60(pwu_pkg::HALF_PI_Q60, 64'(i) << (60 - AB));
      th2  = pwu_pkg::mul_q60(th, th);
      term = th;
      sum  = $signed(th);
      for (int k = 1; k <= 12; k++) begin
        term = pwu_pkg::mul_q60(term, th2) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      rnd  = (64'(sum) + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
      r[i] = rnd[FRAC_BITS:0];
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [1:0]           quad;
  logic [AB-1:0]        addr_a;
  logic [AB:0]          addr;
  logic [FRAC_BITS:0]   rom_q;
  logic                 neg_q;
  logic signed [FRAC_BITS-1:0] saw;
  logic signed [FRAC_BITS:0]   saw_abs;
  logic signed [OW-1:0] lin_d, lin_q;
  logic signed [OW-1:0] sine_val;
  logic signed [OW-1:0] op_d, op_q;

  generate
    if (PB >= AB) begin : g_addr_trunc
      assign addr_a = u_i[PB-1 -: AB];
    end else begin : g_addr_pad
      assign addr_a = {u_i[PB-1:0], {(AB - PB){1'b0}}};
    end
  endgenerate

  // The quarter-turn shift of pseudo-gauss only moves the quadrant.
  always_comb begin
    quad = u_i[FRAC_BITS-1:FRAC_BITS-2];
    if (wave_sel_i == pwu_pkg::WAVE_GAUSS) begin
      quad = quad + 2'd1;
    end
    addr = quad[0] ? ((AB+1)'(TAB_N) - {1'b0, addr_a}) : {1'b0, addr_a};
  end

  // Sawtooth is the fraction read as a signed value; triangle is one minus its magnitude.
  always_comb begin
    saw     = $signed(u_i);
    saw_abs = (saw < 0) ? -(FRAC_BITS+1)'(saw) : (FRAC_BITS+1)'(saw);
    if (wave_sel_i == pwu_pkg::WAVE_SAW) begin
      lin_d = OW'(saw);
    end else begin
      lin_d = (OW'(1) <<< FRAC_BITS) - OW'(saw_abs);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rom_q <= SINE_ROM[addr];
      neg_q <= quad[1];
      lin_q <= lin_d;
    end
  end

  always_comb begin
    sine_val = neg_q ? -$signed({2'b00, rom_q}) : $signed({2'b00, rom_q});
    case (wave_sel_i)
      pwu_pkg::WAVE_SINE:  op_d = sine_val;
      pwu_pkg::WAVE_GAUSS: op_d = sine_val + (OW'(1) <<< FRAC_BITS);
      default:             op_d = lin_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      op_q <= op_d;
    end
  end

  assign op_o = op_q;

endmodule

// ----- hdl/pwu_scale.sv -----
// Output stages: amplitude multiply, floor shift and saturation to 32 bits.
`timescale 1ns / 1ps

module pwu_scale #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic [1:0]                  en_i,
  input  pwu_pkg::wave_e              wave_sel_i,
  input  logic [31:0]                 amp_i,
  input  logic signed [FRAC_BITS+2:0] op_i,
  output logic [31:0]                 wave_value_o,
  output logic                        saturated_o
);

  localparam int PRW = 32 + FRAC_BITS + 3;

  logic signed [PRW-1:0] prod_d, prod_q;
  logic signed [PRW-1:0] sh_f, sh_g;
  logic        [34:0]    r;
  logic                  fits;
  logic        [31:0]    value_d, value_q;
  logic                  sat_d, sat_q;

  assign prod_d = $signed(amp_i) * op_i;

  // Arithmetic right shift is the floor division by a power of two.
  always_comb begin
    sh_f  = prod_q >>> FRAC_BITS;
    sh_g  = prod_q >>> (FRAC_BITS + 1);
    r     = (wave_sel_i == pwu_pkg::WAVE_GAUSS) ? sh_g[34:0] : sh_f[34:0];
    fits  = (r[34:31] == {4{r[31]}});
    sat_d = !fits;
    if (fits) begin
      value_d = r[31:0];
    end else begin
      value_d = r[34] ? pwu_pkg::SAT_NEG : pwu_pkg::SAT_POS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
    end
    if (en_i[1]) begin
      value_q <= value_d;
      sat_q   <= sat_d;
    end
  end

  assign wave_value_o = value_q;
  assign saturated_o  = sat_q;

endmodule

// ----- hdl/periodic_waveform_unit.sv -----
// Top level of the periodic waveform unit: configuration registers and pipeline control.
// Throughput: one sample per cycle while the output is not stalled.
// The seven register stages each hold one item.
// A stall on the output backs up only as far as the pipeline is full, so bubbles close up.
// Reset clears all stage valid bits and loads the registers with their reset values:
// sawtooth, zero phase, unit span reciprocal and unit amplitude.
`timescale 1ns / 1ps

module periodic_waveform_unit #(
  parameter int SINE_TABLE_ADDR_BITS = 10,
  parameter int FRAC_BITS            = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [pwu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pwu_pkg::DATA_W-1:0]    cfg_wdata_i,
  // Sample input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   sample_x_i,
  // Result output channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   wave_value_o,
  output logic                          saturated_o
);

  localparam int NS = pwu_pkg::N_STAGES;

  pwu_pkg::wave_e wave_sel_q;
  logic [31:0]    phase_q;
  logic [31:0]    inv_span_q;
  logic [31:0]    amp_q;

  logic [NS-1:0]  valid_q;
  logic [NS-1:0]  valid_d;
  logic [NS-1:0]  en;

  logic [FRAC_BITS-1:0]        u;
  logic signed [FRAC_BITS+2:0] op;

  // The user must change configuration only while the pipeline is empty, and the
  // block does not check it. Stages read these registers, not a copy per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_sel_q <= pwu_pkg::WAVE_SAW;
      phase_q    <= '0;
      inv_span_q <= pwu_pkg::INV_SPAN_RESET;
      amp_q      <= pwu_pkg::AMPLITUDE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pwu_pkg::CFG_WAVE_SELECT:  wave_sel_q <= pwu_pkg::wave_e'(cfg_wdata_i[1:0]);
        pwu_pkg::CFG_PHASE_OFFSET: phase_q    <= cfg_wdata_i;
        pwu_pkg::CFG_INV_SPAN:     inv_span_q <= cfg_wdata_i;
        pwu_pkg::CFG_AMPLITUDE:    amp_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves on.
  // The last stage is the output register, which moves on when not stalled.
  always_comb begin
    en[NS-1] = !valid_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[NS-1];

  // Stages one to three: phase in turns, fraction of a turn.
  pwu_phase #(
    .FRAC_BITS (FRAC_BITS)
  ) u_phase (
    .clk_i      (clk_i),
    .en_i       (en[2:0]),
    .wave_sel_i (wave_sel_q),
    .phase_i    (phase_q),
    .inv_span_i (inv_span_q),
    .sample_x_i (sample_x_i),
    .u_o        (u)
  );

  // Stages four and five: table read and the waveform value in Q format.
  pwu_wave_rom #(
    .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS),
    .FRAC_BITS            (FRAC_BITS)
  ) u_wave_rom (
    .clk_i      (clk_i),
    .en_i       (en[4:3]),
    .wave_sel_i (wave_sel_q),
    .u_i        (u),
    .op_o       (op)
  );

  // Stages six and seven: amplitude product, then the saturated output register.
  pwu_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk_i        (clk_i),
    .en_i         (en[6:5]),
    .wave_sel_i   (wave_sel_q),
    .amp_i        (amp_q),
    .op_i         (op),
    .wave_value_o (wave_value_o),
    .saturated_o  (saturated_o)
  );

endmodule

// ----- sim/pwu_checker.sv -----
// Scoreboard for the periodic waveform unit: tracks register writes, predicts and checks results.
`timescale 1ns / 1ps

module pwu_checker #(
  parameter int SINE_TABLE_ADDR_BITS = 10,
  parameter int FRAC_BITS            = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pwu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pwu_pkg::DATA_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [31:0]                   sample_x_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [31:0]                   wave_value_i,
  input  logic                          saturated_i,
  output int                            pending_o,
  output int                            fail_count_o
);

  localparam int unsigned LUT_N = 1 << SINE_TABLE_ADDR_BITS;
  // pi/2 with 60 fractional bits.
  localparam logic [63:0] HALF_PI_FX60 = 64'h1921_FB54_442D_1846;
  localparam logic signed [63:0] ONE_Q   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] RES_MAX = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] RES_MIN = -64'sh8000_0000;
  localparam logic [FRAC_BITS-1:0] QUARTER_TURN = 1 << (FRAC_BITS - 2);

  typedef struct packed {
    logic [31:0] sample;
    logic [31:0] value;
    logic        sat;
  } wave_expect_t;

  wave_expect_t expected_q[$];
  wave_expect_t want;
  int           fail_count = 0;
  int           sine_lut[0:LUT_N];

  // Shadow copy of the configuration registers.
  pwu_pkg::wave_e wave_mode  = pwu_pkg::WAVE_SAW;
  logic [31:0]    phase_reg  = '0;
  logic [31:0]    span_reg   = pwu_pkg::INV_SPAN_RESET;
  logic [31:0]    gain_reg   = pwu_pkg::AMPLITUDE_RESET;

  function automatic logic [63:0] fx60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b};
    return 64'(full >> 60);
  endfunction

  // Quarter-wave table from a Taylor series in 60-bit fixed point, rounded to FRAC_BITS.
  initial begin : build_lut
    logic [63:0]        theta;
    logic [63:0]        theta_sq;
    logic [63:0]        term;
    logic signed [63:0] acc;
    for (int i = 0; i <= int'(LUT_N); i++) begin
      theta    = fx60_mul(HALF_PI_FX60, 64'(i) << (60 - SINE_TABLE_ADDR_BITS));
      theta_sq = fx60_mul(theta, theta);
      term     = theta;
      acc      = theta;
      for (int k = 1; k <= 12; k++) begin
        term = fx60_mul(term, theta_sq) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) acc = 0;
      sine_lut[i] = int'((64'(acc) + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
    end
  end

  // Two top bits pick the quadrant; the rest are truncated to a table address.
  function automatic logic signed [63:0] sine_lookup(input logic [FRAC_BITS-1:0] turn_frac);
    logic [FRAC_BITS-3:0] pos;
    int unsigned          addr;
    logic signed [63:0]   mag;
    pos  = turn_frac[FRAC_BITS-3:0];
    addr = (pos >> (FRAC_BITS - 2 - SINE_TABLE_ADDR_BITS)) & (LUT_N - 1);
    if (turn_frac[FRAC_BITS-2]) begin
      mag = sine_lut[LUT_N - addr];
    end else begin
      mag = sine_lut[addr];
    end
    return turn_frac[FRAC_BITS-1] ? -mag : mag;
  endfunction

  function automatic wave_expect_t predict_wave(input logic [31:0] x);
    logic signed [63:0]   xs;
    logic signed [63:0]   phs;
    logic signed [63:0]   ampl;
    logic signed [63:0]   sfrac;
    logic signed [63:0]   r;
    logic [63:0]          turns;
    logic [FRAC_BITS-1:0] frac;
    wave_expect_t         res;
    xs    = $signed(x);
    phs   = $signed(phase_reg);
    ampl  = $signed(gain_reg);
    turns = (xs - phs) * {32'd0, span_reg};
    frac  = turns[2*FRAC_BITS-1:FRAC_BITS];
    sfrac = frac;
    if (frac[FRAC_BITS-1]) sfrac = sfrac - ONE_Q;
    case (wave_mode)
      pwu_pkg::WAVE_SAW: begin
        r = (ampl * sfrac) >>> FRAC_BITS;
      end
      pwu_pkg::WAVE_TRI: begin
        if (sfrac < 0) sfrac = -sfrac;
        r = (ampl * (ONE_Q - sfrac)) >>> FRAC_BITS;
      end
      pwu_pkg::WAVE_SINE: begin
        // Phase offset enters at half weight here.
        turns = xs * {32'd0, span_reg} - (phs << (FRAC_BITS - 1));
        frac  = turns[2*FRAC_BITS-1:FRAC_BITS];
        r     = (ampl * sine_lookup(frac)) >>> FRAC_BITS;
      end
      default: begin
        frac = frac + QUARTER_TURN;
        r    = (ampl * (sine_lookup(frac) + ONE_Q)) >>> (FRAC_BITS + 1);
      end
    endcase
    res.sample = x;
    res.sat    = 1'b0;
    if (r > RES_MAX) begin
      r       = RES_MAX;
      res.sat = 1'b1;
    end
    if (r < RES_MIN) begin
      r       = RES_MIN;
      res.sat = 1'b1;
    end
    res.value = r[31:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_mode = pwu_pkg::WAVE_SAW;
      phase_reg = '0;
      span_reg  = pwu_pkg::INV_SPAN_RESET;
      gain_reg  = pwu_pkg::AMPLITUDE_RESET;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_wave(sample_x_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result with nothing outstanding: value %h sat %b",
                     $realtime, wave_value_i, saturated_i);
          end
        end else begin
          want = expected_q.pop_front();
          if (wave_value_i !== want.value || saturated_i !== want.sat) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: x %h mode %s: expected value %h sat %b, got value %h sat %b",
                       $realtime, want.sample, wave_mode.name(), want.value, want.sat,
                       wave_value_i, saturated_i);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pwu_pkg::CFG_WAVE_SELECT:  wave_mode = pwu_pkg::wave_e'(cfg_wdata_i[1:0]);
          pwu_pkg::CFG_PHASE_OFFSET: phase_reg = cfg_wdata_i;
          pwu_pkg::CFG_INV_SPAN:     span_reg  = cfg_wdata_i;
          pwu_pkg::CFG_AMPLITUDE:    gain_reg  = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o    <= expected_q.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

// ----- sim/tb_periodic_waveform_unit.sv -----
// Testbench top for the periodic waveform unit: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_periodic_waveform_unit;

  localparam int LUT_BITS   = 10;
  localparam int FRAC       = 16;
  // Cycles without any handshake before the run is declared hung.
  localparam int HANG_LIMIT = 4000;

  // Pacing modes: how often the sender idles and the receiver stalls.
  typedef enum int {
    PACE_FULL,
    PACE_SENDER_GAPS,
    PACE_RECEIVER_STALLS,
    PACE_BOTH
  } pace_e;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [pwu_pkg::CFG_IDX_W-1:0] cfg_idx   = pwu_pkg::CFG_WAVE_SELECT;
  logic [pwu_pkg::DATA_W-1:0]    cfg_wdata = '0;
  logic                          in_valid  = 1'b0;
  logic [31:0]                   sample_x  = '0;
  logic                          out_stall = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic [31:0]                   wave_value;
  logic                          saturated;
  int                            pending;
  int                            fail_count;
  int                            send_idle_pct  = 0;
  int                            recv_stall_pct = 0;
  int                            quiet_cycles   = 0;

  always #1 clk = ~clk;

  periodic_waveform_unit #(
    .SINE_TABLE_ADDR_BITS (LUT_BITS),
    .FRAC_BITS            (FRAC)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sample_x_i   (sample_x),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .wave_value_o (wave_value),
    .saturated_o  (saturated)
  );

  pwu_checker #(
    .SINE_TABLE_ADDR_BITS (LUT_BITS),
    .FRAC_BITS            (FRAC)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .sample_x_i   (sample_x),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .wave_value_i (wave_value),
    .saturated_i  (saturated),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // The receiver decides afresh every cycle whether to stall, so stalls land on
  // every pipeline phase, including cycles where the output is not valid.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // The watchdog restarts whenever either channel moves an item. A stuck
  // handshake or a lost result ends the run as a failure.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic set_pace(input pace_e mode);
    case (mode)
      PACE_FULL: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      PACE_SENDER_GAPS: begin
        send_idle_pct  = 82;
        recv_stall_pct = 0;
      end
      PACE_RECEIVER_STALLS: begin
        send_idle_pct  = 0;
        recv_stall_pct = 82;
      end
      default: begin
        send_idle_pct  = 24;
        recv_stall_pct = 24;
      end
    endcase
  endtask

  // Offers one item and returns at the edge where it is taken. While idle the
  // data lines carry junk; once valid is up they hold still until accepted.
  task automatic push_sample(input logic [31:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      sample_x <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_x <= x;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering items and waits until every prediction has been matched.
  // The checker's count is registered, so an edge passes before it is read.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pwu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pwu_pkg::DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Registers are only rewritten once the pipeline is empty. The extra wait
  // covers the pipeline depth; the write enable drops only after the last
  // write so it is never lowered and raised within one time step.
  task automatic program_unit(input pwu_pkg::wave_e mode, input logic [31:0] phase,
                              input logic [31:0] span, input logic [31:0] gain);
    wait_results_done();
    repeat (pwu_pkg::N_STAGES) @(posedge clk);
    // The upper bits of the mode write are don't-care and get random values.
    write_reg(pwu_pkg::CFG_WAVE_SELECT, {30'($urandom), mode});
    write_reg(pwu_pkg::CFG_PHASE_OFFSET, phase);
    write_reg(pwu_pkg::CFG_INV_SPAN, span);
    write_reg(pwu_pkg::CFG_AMPLITUDE, gain);
    cfg_we <= 1'b0;
  endtask

  // Random, or with a chance of corner_pct percent one of the corner values of a signed Q16.16 field.
  function automatic logic [31:0] corner_or_random(input int corner_pct);
    if ($urandom_range(99) >= corner_pct) return $urandom;
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  initial begin : stimulus
    pwu_pkg::wave_e mode;
    logic [31:0]    phase;
    logic [31:0]    span;
    logic [31:0]    gain;
    logic [31:0]    x;

    set_pace(PACE_BOTH);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset values: unit sawtooth. Covers both ends of the
    // input range and the wrap of the sawtooth at half a turn.
    push_sample(32'h0000_0000);
    push_sample(32'h7FFF_FFFF);
    push_sample(32'h8000_0000);
    push_sample(32'h0000_8000);
    push_sample(32'h0000_7FFF);

    // Triangle with a phase offset, two and a half turns per unit and maximum gain.
    program_unit(pwu_pkg::WAVE_TRI, 32'h0001_2345, 32'h0002_8000, 32'h7FFF_FFFF);
    push_sample(32'h0001_2345);
    push_sample(32'h0001_6345);
    push_sample(32'hFFFF_0000);

    // Sine with the most negative gain: the negative peak of the sine gives a
    // product one past the positive limit, which must clip and flag.
    program_unit(pwu_pkg::WAVE_SINE, 32'h0000_0000, 32'h0001_0000, 32'h8000_0000);
    push_sample(32'h0000_4000);
    push_sample(32'h0000_C000);
    push_sample(32'h0000_0000);
    push_sample(32'h0000_8000);

    // Pseudo-gauss with the largest span reciprocal and phase offset at the
    // negative end, so the turn count runs far past the 32 bits that are kept and wraps.
    program_unit(pwu_pkg::WAVE_GAUSS, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    push_sample(32'h7FFF_FFFF);
    push_sample(32'h8000_0000);
    push_sample(32'h1234_5678);

    // Zero span reciprocal: the phase never moves, so the output is constant.
    program_unit(pwu_pkg::WAVE_SAW, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
    push_sample(32'h1111_1111);
    push_sample(32'hDEAD_BEEF);

    // Sine with a one-unit phase offset, which shifts the sine by half a turn.
    program_unit(pwu_pkg::WAVE_SINE, 32'h0001_0000, 32'h0000_4000, 32'hFFFF_0000);
    push_sample(32'h0000_0000);
    push_sample(32'h0003_0000);

    // Random part: each phase fixes a waveform and a pacing mode, so every
    // waveform is seen under two handshake patterns.
    for (int p = 0; p < 8; p++) begin
      mode  = pwu_pkg::wave_e'(p % 4);
      phase = corner_or_random(30);
      gain  = corner_or_random(30);
      case ($urandom_range(7))
        0:       span = 32'h0000_0000;
        1:       span = 32'hFFFF_FFFF;
        2:       span = 32'h0001_0000;
        3, 4:    span = 32'($urandom_range(32'h0004_0000, 1));
        default: span = $urandom;
      endcase
      if (p == 0) begin
        phase = 32'h8000_0000;
        span  = 32'hFFFF_FFFF;
        gain  = 32'h7FFF_FFFF;
      end
      if (p == 6) begin
        phase = 32'h7FFF_FFFF;
        gain  = 32'h8000_0000;
      end
      program_unit(mode, phase, span, gain);
      set_pace(pace_e'(p / 2));
      for (int n = 0; n < 100; n++) begin
        // Halfway through, the sender holds off until the pipeline has drained.
        if (n == 50) wait_results_done();
        case ($urandom_range(9))
          6, 7:    x = 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
          8:       x = corner_or_random(100);
          9:       x = (32'($urandom_range(15)) << 14) + 32'($urandom_range(2)) - 32'd1;
          default: x = $urandom;
        endcase
        push_sample(x);
      end
    end

    wait_results_done();
    repeat (2 * pwu_pkg::N_STAGES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
